// File: hw/rtl/plm_pkg.sv
// shared constants and types for the slope limiter
package plm_pkg;

  localparam int DataWidth  = 32;
  localparam int FracBits   = 16;
  localparam int ThetaWidth = 18;
  localparam int ThetaFrac  = 16;
  // value difference and face spacing widths
  localparam int DvWidth    = DataWidth + 1;
  localparam int DxWidth    = DataWidth + 3;
  // numerator of the long division: 2*|dv| shifted by the fraction bits
  localparam int NumWidth   = DvWidth + 1 + FracBits;
  localparam int CntWidth   = $clog2(NumWidth + 1);
  localparam int ProdWidth  = DataWidth + ThetaWidth;

  localparam logic [0:0] RegReconMode   = 1'b0;
  localparam logic [0:0] RegLimiterTheta = 1'b1;

  typedef enum logic [1:0] {
    JOB_SL = 2'd0,
    JOB_SC = 2'd1,
    JOB_SR = 2'd2
  } job_t;

  typedef struct packed {
    logic                 done;
    logic                 bad;
    logic [DataWidth-1:0] quo;
  } div_rsp_t;

endpackage

// File: hw/rtl/plm_if.sv
// valid/ready channels for cell items and slope results
interface plm_in_if;
  logic                          valid;
  logic                          ready;
  logic [plm_pkg::DataWidth-1:0] cell_value;
  logic [plm_pkg::DataWidth-1:0] left_face;
  logic [plm_pkg::DataWidth-1:0] right_face;
  logic                          first_cell;
  logic                          final_cell;
  modport source (output valid, cell_value, left_face, right_face, first_cell, final_cell,
                  input ready);
  modport sink (input valid, cell_value, left_face, right_face, first_cell, final_cell,
                output ready);
endinterface

interface plm_out_if;
  logic                          valid;
  logic                          ready;
  logic [plm_pkg::DataWidth-1:0] slope;
  logic                          is_grid_end;
  logic                          run_last;
  logic                          bad_spacing;
  modport source (output valid, slope, is_grid_end, run_last, bad_spacing, input ready);
  modport sink (input valid, slope, is_grid_end, run_last, bad_spacing, output ready);
endinterface

// File: hw/rtl/plm_divider.sv
// bit-serial divider giving a saturated 2*dv/dx in fixed point
module plm_divider (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [plm_pkg::DvWidth-1:0]  dv,
  input  logic signed [plm_pkg::DxWidth-1:0]  dx,
  output plm_pkg::div_rsp_t                   rsp
);

  localparam int DW = plm_pkg::DataWidth;
  localparam int NW = plm_pkg::NumWidth;
  localparam int XW = plm_pkg::DxWidth;
  localparam logic [NW-1:0] LimPos = NW'((64'd1 << (DW - 1)) - 64'd1);
  localparam logic [NW-1:0] LimNeg = NW'(64'd1 << (DW - 1));

  logic                        busy_r;
  logic [plm_pkg::CntWidth-1:0] cnt_r;
  logic [NW-1:0]               num_r;
  logic [XW-1:0]               rem_r;
  logic [XW-1:0]               den_r;
  logic                        neg_r;
  logic                        done_r;
  logic                        bad_r;
  logic [DW-1:0]               quo_r;

  logic [plm_pkg::DvWidth-1:0] dv_mag;
  logic [XW-1:0]               dx_mag;
  logic [XW:0]                 rem_try;
  logic                        ge;
  logic [NW-1:0]               lim;
  logic [DW-1:0]               m;

  // operand magnitudes
  assign dv_mag = dv[plm_pkg::DvWidth-1] ? plm_pkg::DvWidth'(-dv) : dv;
  assign dx_mag = dx[XW-1] ? XW'(-dx) : dx;

  // one restoring step per cycle
  assign rem_try = {rem_r, num_r[NW-1]};
  assign ge      = rem_try >= {1'b0, den_r};

  // saturation of the final quotient
  assign lim = neg_r ? LimNeg : LimPos;
  assign m   = (num_r > lim) ? DW'(lim) : DW'(num_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        if (dx == '0) begin
          done_r <= 1'b1;
          bad_r  <= 1'b1;
          quo_r  <= '0;
        end else begin
          busy_r <= 1'b1;
          cnt_r  <= plm_pkg::CntWidth'(NW);
          num_r  <= {dv_mag, 1'b0, {plm_pkg::FracBits{1'b0}}};
          rem_r  <= '0;
          den_r  <= dx_mag;
          neg_r  <= dv[plm_pkg::DvWidth-1] ^ dx[XW-1];
        end
      end else if (busy_r) begin
        if (cnt_r != '0) begin
          rem_r <= ge ? XW'(rem_try - {1'b0, den_r}) : XW'(rem_try);
          num_r <= {num_r[NW-2:0], ge};
          cnt_r <= cnt_r - 1'b1;
        end else begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          bad_r  <= 1'b0;
          quo_r  <= neg_r ? DW'(-m) : m;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.bad  = bad_r;
  assign rsp.quo  = quo_r;

endmodule

// File: hw/rtl/plm_slope_limiter.sv
// top level: sequencer around a shared divider and multiplier for limited slopes
// Usage: cells of one grid stream enter on in_item, one per handshake, with their
// value and faces; first_cell starts a stream and final_cell ends it. Slopes leave
// on out_item one cell late; the final cell yields two results (the slope of the
// cell before and its own one-sided slope). A cell marked first and final gives a
// single zero slope. run_last flags the last result of an accepted item.
// Timing: an item that only opens a stream returns the sequencer straight to idle; an
// item whose slope needs a single division runs it alone, and an interior cell runs three
// spacing divisions one after another on the bit-serial divider (each: load, 50 quotient
// bits, finish and hand-off) followed by two theta products on the shared multiplier,
// the minmod selection and the result state; a final cell adds a second result state.
// in_item.ready is high only while the sequencer waits for a new item. Results sit in an
// output register; a stalled receiver holds it, and the block keeps accepting the next
// item, stopping only when a new result needs the register.
// Configuration: cfg_we writes recon_mode (index 0) or limiter_theta (index 1);
// write only while idle. Reset: synchronous active-low rst_n empties the grid
// window, drops any pending result and restores recon_mode 1 and theta 1.0.
module plm_slope_limiter (
  input  logic                               clk,
  input  logic                               rst_n,
  plm_in_if.sink                             in_item,
  plm_out_if.source                          out_item,
  input  logic                               cfg_we,
  input  logic [0:0]                         cfg_index,
  input  logic [plm_pkg::ThetaWidth-1:0]     cfg_wdata
);

  localparam int DW = plm_pkg::DataWidth;
  localparam int PW = plm_pkg::ProdWidth;
  localparam int SW = PW - plm_pkg::ThetaFrac;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_START = 9'b000000010,
    S_WAIT  = 9'b000000100,
    S_MULL  = 9'b000001000,
    S_SATL  = 9'b000010000,
    S_MULR  = 9'b000100000,
    S_SATR  = 9'b001000000,
    S_EMIT1 = 9'b010000000,
    S_EMIT2 = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  logic                           mode_r;
  logic [plm_pkg::ThetaWidth-1:0] theta_r;
  logic [1:0]                     seen_r;
  logic signed [DW-1:0]           p0_r, p1_r, f0_r, f1_r, f2_r, v_r, rf_r;
  logic                           fin_r;
  plm_pkg::job_t                  job_r;
  logic signed [DW-1:0]           sl_r, sc_r, sr_r, tl_r, res_r;
  logic                           bad_any_r, bad_sr_r, res_bad_r;
  logic [PW-1:0]                  prod_r;
  logic                           pneg_r;

  logic                           out_vld_r;
  logic [DW-1:0]                  out_slope_r;
  logic                           out_end_r, out_last_r, out_bad_r;

  logic                           div_start;
  logic signed [plm_pkg::DvWidth-1:0] div_dv;
  logic signed [plm_pkg::DxWidth-1:0] div_dx;
  plm_pkg::div_rsp_t              div_rsp;
  logic                           slot_free;
  logic                           in_acc;
  logic signed [DW-1:0]           mul_src;
  logic [DW-1:0]                  mul_mag;
  logic [SW-1:0]                  scaled;
  logic [SW-1:0]                  sat_lim;
  logic signed [DW-1:0]           sat_val;

  // minmod of three with tie rules of the limiter
  function automatic logic signed [DW-1:0] minmod3(input logic signed [DW-1:0] a,
                                                   input logic signed [DW-1:0] b,
                                                   input logic signed [DW-1:0] c);
    logic signed [DW-1:0] mm;
    logic [DW-1:0]        ma, mb, mc, mmm;
    ma = a[DW-1] ? DW'(-a) : a;
    mb = b[DW-1] ? DW'(-b) : b;
    mc = c[DW-1] ? DW'(-c) : c;
    if ((a < 0 && b > 0) || (a > 0 && b < 0)) mm = '0;
    else if (ma < mb) mm = a;
    else mm = b;
    mmm = mm[DW-1] ? DW'(-mm) : mm;
    if ((mm < 0 && c > 0) || (mm > 0 && c < 0)) mm = '0;
    else if (mc < mmm) mm = c;
    return mm;
  endfunction

  assign in_acc    = in_item.valid && in_item.ready;
  assign slot_free = !out_vld_r || out_item.ready;
  assign in_item.ready = (state_r == S_IDLE);

  // divider operands per job
  always_comb begin
    div_dv = plm_pkg::DvWidth'(v_r) - plm_pkg::DvWidth'(p1_r);
    div_dx = plm_pkg::DxWidth'(rf_r) - plm_pkg::DxWidth'(f1_r);
    case (job_r)
      plm_pkg::JOB_SL: begin
        div_dv = plm_pkg::DvWidth'(p1_r) - plm_pkg::DvWidth'(p0_r);
        div_dx = plm_pkg::DxWidth'(f2_r) - plm_pkg::DxWidth'(f0_r);
      end
      plm_pkg::JOB_SC: begin
        div_dv = plm_pkg::DvWidth'(v_r) - plm_pkg::DvWidth'(p0_r);
        div_dx = plm_pkg::DxWidth'(rf_r) + plm_pkg::DxWidth'(f2_r)
               - plm_pkg::DxWidth'(f1_r) - plm_pkg::DxWidth'(f0_r);
      end
      default: ;
    endcase
  end

  assign div_start = (state_r == S_START);

  plm_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .dv    (div_dv),
    .dx    (div_dx),
    .rsp   (div_rsp)
  );

  // shared theta multiplier input and saturation of its product
  assign mul_src = (state_r == S_MULL) ? sl_r : sr_r;
  assign mul_mag = mul_src[DW-1] ? DW'(-mul_src) : mul_src;
  assign scaled  = prod_r[PW-1:plm_pkg::ThetaFrac];
  assign sat_lim = pneg_r ? SW'(64'd1 << (DW - 1)) : SW'((64'd1 << (DW - 1)) - 64'd1);
  always_comb begin
    sat_val = (scaled > sat_lim) ? DW'(sat_lim) : DW'(scaled);
    if (pneg_r) sat_val = DW'(-sat_val);
  end

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_item.first_cell || seen_r == 2'd0)
            state_nxt = in_item.final_cell ? S_EMIT2 : S_IDLE;
          else state_nxt = S_START;
        end
      end
      S_START: state_nxt = S_WAIT;
      S_WAIT: begin
        if (div_rsp.done) begin
          if (job_r != plm_pkg::JOB_SR) state_nxt = S_START;
          else if (seen_r == 2'd2) state_nxt = S_MULL;
          else state_nxt = S_EMIT1;
        end
      end
      S_MULL:  state_nxt = S_SATL;
      S_SATL:  state_nxt = S_MULR;
      S_MULR:  state_nxt = S_SATR;
      S_SATR:  state_nxt = S_EMIT1;
      S_EMIT1: if (slot_free) state_nxt = fin_r ? S_EMIT2 : S_IDLE;
      S_EMIT2: if (slot_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      seen_r    <= 2'd0;
      mode_r    <= 1'b1;
      theta_r   <= plm_pkg::ThetaWidth'(1 << plm_pkg::ThetaFrac);
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          plm_pkg::RegReconMode:    mode_r  <= cfg_wdata[0];
          plm_pkg::RegLimiterTheta: theta_r <= cfg_wdata;
          default: ;
        endcase
      end
      if ((state_r == S_EMIT1 || state_r == S_EMIT2) && slot_free) out_vld_r <= 1'b1;
      else if (out_item.ready) out_vld_r <= 1'b0;
      if (state_r == S_IDLE && in_acc) begin
        if (in_item.first_cell || seen_r == 2'd0)
          seen_r <= in_item.final_cell ? 2'd0 : 2'd1;
      end
      if (state_r == S_EMIT1 && slot_free && !fin_r) seen_r <= 2'd2;
      if (state_r == S_EMIT2 && slot_free) seen_r <= 2'd0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          v_r       <= in_item.cell_value;
          rf_r      <= in_item.right_face;
          fin_r     <= in_item.final_cell;
          bad_any_r <= 1'b0;
          if (in_item.first_cell || seen_r == 2'd0) begin
            p1_r     <= in_item.cell_value;
            f1_r     <= in_item.left_face;
            f2_r     <= in_item.right_face;
            sr_r     <= '0;
            bad_sr_r <= 1'b0;
          end else begin
            job_r <= (seen_r == 2'd2) ? plm_pkg::JOB_SL : plm_pkg::JOB_SR;
          end
        end
      end
      S_WAIT: begin
        if (div_rsp.done) begin
          bad_any_r <= bad_any_r | div_rsp.bad;
          case (job_r)
            plm_pkg::JOB_SL: begin
              sl_r  <= div_rsp.quo;
              job_r <= plm_pkg::JOB_SC;
            end
            plm_pkg::JOB_SC: begin
              sc_r  <= div_rsp.quo;
              job_r <= plm_pkg::JOB_SR;
            end
            default: begin
              sr_r      <= div_rsp.quo;
              bad_sr_r  <= div_rsp.bad;
              res_r     <= div_rsp.quo;
              res_bad_r <= div_rsp.bad;
            end
          endcase
        end
      end
      S_MULL, S_MULR: begin
        prod_r <= PW'(mul_mag * theta_r);
        pneg_r <= mul_src[DW-1];
      end
      S_SATL: tl_r <= sat_val;
      S_SATR: begin
        res_r     <= bad_any_r ? '0 : minmod3(tl_r, sc_r, sat_val);
        res_bad_r <= bad_any_r;
      end
      S_EMIT1: begin
        if (slot_free) begin
          out_slope_r <= mode_r ? res_r : '0;
          out_bad_r   <= mode_r & res_bad_r;
          out_end_r   <= 1'b0;
          out_last_r  <= !fin_r;
          if (!fin_r) begin
            p0_r <= p1_r;
            p1_r <= v_r;
            f0_r <= f1_r;
            f1_r <= f2_r;
            f2_r <= rf_r;
          end
        end
      end
      S_EMIT2: begin
        if (slot_free) begin
          out_slope_r <= mode_r ? sr_r : '0;
          out_bad_r   <= mode_r & bad_sr_r;
          out_end_r   <= 1'b1;
          out_last_r  <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_item.valid       = out_vld_r;
  assign out_item.slope       = out_slope_r;
  assign out_item.is_grid_end = out_end_r;
  assign out_item.run_last    = out_last_r;
  assign out_item.bad_spacing = out_bad_r;

endmodule

// File: hw/rtl/plm_checker.sv
// port-level checks for the slope limiter and their bind
module plm_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [plm_pkg::DataWidth-1:0] out_slope,
  input logic                          out_is_grid_end,
  input logic                          out_run_last,
  input logic                          out_bad_spacing
);

  // a stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // the slope of the final cell always closes its item
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_grid_end |-> out_run_last)
    else $error("grid end result not marked last");

  // a zero spacing gives a zero slope
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_spacing |-> out_slope == '0)
    else $error("bad spacing with nonzero slope");

  // reset empties the output register
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind plm_slope_limiter plm_checker u_plm_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_item.valid),
  .out_ready       (out_item.ready),
  .out_slope       (out_item.slope),
  .out_is_grid_end (out_item.is_grid_end),
  .out_run_last    (out_item.run_last),
  .out_bad_spacing (out_item.bad_spacing)
);
